// File: rtl/bb3_pkg.sv
// Shared types, constants and helpers of the 3x3 edge-aware box blur.
// No dependencies; used by bb3_div and box_blur_3x3_edge_aware.
package bb3_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int PIX_W = 24;
	localparam int FW_W = 11;
	localparam int FH_W = 12;
	localparam int CFG_W = 12;
	localparam int SUM_W = 12;
	localparam int X_W = 13;
	localparam int RCP_W = 16;
	localparam int Q_W = 9;

	localparam logic REG_FRAME_WIDTH = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [FW_W-1:0] FW_RESET = 11'd640;
	localparam logic [FH_W-1:0] FH_RESET = 12'd480;

	typedef struct packed {
		logic [7:0] in_blue;
		logic [7:0] in_green;
		logic [7:0] in_red;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [11:0] out_row;
		logic [9:0] out_col;
		logic run_last;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic [3:0] n;
	} div_ctl_t;

	// floor(65536 / (2*n)) for the neighbourhood sizes in use
	function automatic logic [RCP_W-1:0] recip_of(input logic [3:0] n);
		logic [RCP_W-1:0] r;
		case (n)
			4'd1: r = 16'd32768;
			4'd2: r = 16'd16384;
			4'd3: r = 16'd10922;
			4'd4: r = 16'd8192;
			4'd6: r = 16'd5461;
			4'd9: r = 16'd3640;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/bb3_ram.sv
// Single-port-write, single-port-read line buffer RAM with registered read.
// No dependencies.
module bb3_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/bb3_div.sv
// Rounded mean of one channel: floor((2*sum+n)/(2*n)) by reciprocal and correction.
// Depends on bb3_pkg.
module bb3_div (
	input  logic                      clk,
	input  bb3_pkg::div_ctl_t         ctl,
	input  logic [bb3_pkg::SUM_W-1:0] sum,
	output logic [7:0]                mean
);

	logic [bb3_pkg::X_W-1:0] x_q;
	logic [4:0] d_q;
	logic [bb3_pkg::Q_W-1:0] q0_q;
	logic [bb3_pkg::X_W-1:0] x;
	logic [bb3_pkg::X_W+bb3_pkg::RCP_W-1:0] prod;
	logic [bb3_pkg::X_W-1:0] back;
	logic [bb3_pkg::X_W-1:0] rem;

	assign x = {sum, 1'b0} + bb3_pkg::X_W'(ctl.n);
	assign prod = x * bb3_pkg::recip_of(ctl.n);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= x;
			d_q <= {ctl.n, 1'b0};
			q0_q <= prod[bb3_pkg::RCP_W +: bb3_pkg::Q_W];
		end
	end

	always_comb begin
		back = bb3_pkg::X_W'(q0_q) * bb3_pkg::X_W'(d_q);
		rem = x_q - back;
		mean = (rem >= bb3_pkg::X_W'(d_q)) ? 8'(q0_q + 9'd1) : q0_q[7:0];
	end

endmodule

// File: rtl/box_blur_3x3_edge_aware.sv
// Usage: raster-order RGB pixels enter on in_valid/in_ready as in_word; blurred
// pixels leave on out_valid/out_ready as out_word, each tagged with row and column.
// Every pixel yields 0 to 4 result words; run_last marks the last word of a pixel.
// A pixel is taken in the idle state and its line buffers are read in the read
// state; then each result word passes the sum, reciprocal-multiply and correction
// states before it lands in the output register.
// The user writes frame size on cfg_we/cfg_idx/cfg_data only while idle; the block
// does not enforce this. Reset clears the position counters and column-sum windows
// and loads 640x480; line buffers are not cleared and need no clearing pass.
// When the receiver stalls the output register holds its word and the sequencer
// waits; no new pixel is taken until the last result of the current one is loaded into the output register.
// Depends on bb3_pkg, bb3_ram and bb3_div.
module box_blur_3x3_edge_aware (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  bb3_pkg::in_word_t         in_word,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bb3_pkg::out_word_t        out_word,
	input  logic                      cfg_we,
	input  logic                      cfg_idx,
	input  logic [bb3_pkg::CFG_W-1:0] cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_SUM  = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_FIX  = 5'b10000
	} state_t;

	state_t st_q;
	logic [bb3_pkg::FW_W-1:0] fw_q;
	logic [bb3_pkg::FH_W-1:0] fh_q;
	logic [9:0] col_q;
	logic [11:0] row_q;
	logic [9:0] c_q;
	logic [11:0] r_q;
	logic [bb3_pkg::PIX_W-1:0] px_q;
	logic [9:0] cw_q [3][3];
	logic [8:0] bw_q [3][3];
	logic [3:0] mask_q;
	logic [1:0] k_q;
	logic [bb3_pkg::SUM_W-1:0] sum_q [3];
	logic [3:0] n_q;
	logic [11:0] orow_q;
	logic [9:0] ocol_q;
	logic olast_q;
	logic out_valid_q;
	bb3_pkg::out_word_t out_q;

	logic [bb3_pkg::FW_W-1:0] w_eff;
	logic [bb3_pkg::FH_W-1:0] h_eff;
	logic [9:0] c_now;
	logic [12:0] r_inc;
	logic [11:0] r_now;
	logic [10:0] c_nxt;
	logic [12:0] r_nxt;
	logic acc;
	logic [bb3_pkg::PIX_W-1:0] newer_rd, older_rd;
	logic [bb3_pkg::PIX_W-1:0] up_px, upup_px;
	logic rA, rB, cA, cB;
	logic [3:0] mask_n;
	logic [3:0] later;
	logic [1:0] k_first, k_next;
	logic row_b, col_b;
	logic [1:0] cfirst;
	logic [3:0] n_cur;
	logic [bb3_pkg::SUM_W-1:0] s_cur [3];
	logic [7:0] mean [3];
	bb3_pkg::div_ctl_t dctl;
	logic out_free;

	always_comb begin
		w_eff = (fw_q == '0) ? 11'd1 : (fw_q > 11'(bb3_pkg::MAX_WIDTH)) ?
			11'(bb3_pkg::MAX_WIDTH) : fw_q;
		h_eff = (fh_q == '0) ? 12'd1 : fh_q;
		if ({1'b0, col_q} >= w_eff) begin
			c_now = '0;
			r_inc = {1'b0, row_q} + 13'd1;
		end else begin
			c_now = col_q;
			r_inc = {1'b0, row_q};
		end
		r_now = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[11:0];
		c_nxt = {1'b0, c_now} + 11'd1;
		r_nxt = {1'b0, r_now} + 13'd1;
	end

	assign in_ready = (st_q == ST_IDLE);
	assign acc = in_valid && in_ready;

	bb3_ram #(.DEPTH(bb3_pkg::MAX_WIDTH), .WIDTH(bb3_pkg::PIX_W)) u_newer (
		.clk(clk), .we(st_q == ST_READ), .waddr(c_q[bb3_pkg::ADDR_W-1:0]),
		.wdata(px_q), .raddr(c_now[bb3_pkg::ADDR_W-1:0]), .rdata(newer_rd)
	);

	bb3_ram #(.DEPTH(bb3_pkg::MAX_WIDTH), .WIDTH(bb3_pkg::PIX_W)) u_older (
		.clk(clk), .we(st_q == ST_READ), .waddr(c_q[bb3_pkg::ADDR_W-1:0]),
		.wdata(newer_rd), .raddr(c_now[bb3_pkg::ADDR_W-1:0]), .rdata(older_rd)
	);

	always_comb begin
		up_px = (r_q >= 12'd1) ? newer_rd : '0;
		upup_px = (r_q >= 12'd2) ? older_rd : '0;
		rA = (r_q >= 12'd1);
		rB = ({1'b0, r_q} == {1'b0, h_eff} - 13'd1);
		cA = (c_q >= 10'd1);
		cB = ({1'b0, c_q} == w_eff - 11'd1);
		mask_n = {rB & cB, rB & cA, rA & cB, rA & cA};
		k_first = mask_n[0] ? 2'd0 : mask_n[1] ? 2'd1 : mask_n[2] ? 2'd2 : 2'd3;
		later = mask_q & ~((4'd2 << k_q) - 4'd1);
		k_next = later[1] ? 2'd1 : later[2] ? 2'd2 : 2'd3;
		row_b = k_q[1];
		col_b = k_q[0];
		if (col_b) begin
			cfirst = cA ? 2'd1 : 2'd2;
		end else begin
			cfirst = (c_q >= 10'd2) ? 2'd0 : 2'd1;
		end
		if (row_b) begin
			n_cur = (rA ? 4'd2 : 4'd1) * (4'd3 - {2'b00, cfirst});
		end else begin
			n_cur = ((r_q >= 12'd2) ? 4'd3 : 4'd2) * (4'd3 - {2'b00, cfirst});
		end
		for (int ch = 0; ch < 3; ch++) begin
			if (row_b) begin
				s_cur[ch] = 12'(bw_q[2][ch]) +
					((cfirst <= 2'd1) ? 12'(bw_q[1][ch]) : 12'd0) +
					((cfirst == 2'd0) ? 12'(bw_q[0][ch]) : 12'd0);
			end else begin
				s_cur[ch] = 12'(cw_q[2][ch]) +
					((cfirst <= 2'd1) ? 12'(cw_q[1][ch]) : 12'd0) +
					((cfirst == 2'd0) ? 12'(cw_q[0][ch]) : 12'd0);
			end
		end
	end

	assign dctl.load = (st_q == ST_MUL);
	assign dctl.n = n_q;

	for (genvar g = 0; g < 3; g++) begin : g_div
		bb3_div u_div (.clk(clk), .ctl(dctl), .sum(sum_q[g]), .mean(mean[g]));
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			fw_q <= bb3_pkg::FW_RESET;
			fh_q <= bb3_pkg::FH_RESET;
			col_q <= '0;
			row_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int ch = 0; ch < 3; ch++) begin
					cw_q[i][ch] <= '0;
					bw_q[i][ch] <= '0;
				end
			end
		end else begin
			if (cfg_we) begin
				if (cfg_idx == bb3_pkg::REG_FRAME_WIDTH) begin
					fw_q <= cfg_data[bb3_pkg::FW_W-1:0];
				end else begin
					fh_q <= cfg_data[bb3_pkg::FH_W-1:0];
				end
			end
			if (st_q == ST_FIX && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (acc) begin
						if (c_nxt >= w_eff) begin
							col_q <= '0;
							row_q <= (r_nxt >= {1'b0, h_eff}) ? '0 : r_nxt[11:0];
						end else begin
							col_q <= c_nxt[9:0];
							row_q <= r_now;
						end
						st_q <= ST_READ;
					end
				end
				ST_READ: begin
					for (int ch = 0; ch < 3; ch++) begin
						cw_q[0][ch] <= cw_q[1][ch];
						cw_q[1][ch] <= cw_q[2][ch];
						cw_q[2][ch] <= 10'(upup_px[8*ch +: 8]) + 10'(up_px[8*ch +: 8]) +
							10'(px_q[8*ch +: 8]);
						bw_q[0][ch] <= bw_q[1][ch];
						bw_q[1][ch] <= bw_q[2][ch];
						bw_q[2][ch] <= 9'(up_px[8*ch +: 8]) + 9'(px_q[8*ch +: 8]);
					end
					st_q <= (mask_n == '0) ? ST_IDLE : ST_SUM;
				end
				ST_SUM: begin
					st_q <= ST_MUL;
				end
				ST_MUL: begin
					st_q <= ST_FIX;
				end
				ST_FIX: begin
					if (out_free) begin
						st_q <= (later == '0) ? ST_IDLE : ST_SUM;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			c_q <= c_now;
			r_q <= r_now;
			px_q <= in_word;
		end
		if (st_q == ST_READ) begin
			mask_q <= mask_n;
			k_q <= k_first;
		end
		if (st_q == ST_SUM) begin
			for (int ch = 0; ch < 3; ch++) begin
				sum_q[ch] <= s_cur[ch];
			end
			n_q <= n_cur;
			orow_q <= row_b ? r_q : r_q - 12'd1;
			ocol_q <= col_b ? c_q : c_q - 10'd1;
			olast_q <= (later == '0);
		end
		if (st_q == ST_FIX && out_free) begin
			out_q.out_red <= mean[0];
			out_q.out_green <= mean[1];
			out_q.out_blue <= mean[2];
			out_q.out_row <= orow_q;
			out_q.out_col <= ocol_q;
			out_q.run_last <= olast_q;
			if (later != '0) begin
				k_q <= k_next;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word = out_q;

`ifndef SYNTHESIS
	a_acc_read: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (st_q == ST_READ && !in_ready))
		else $error("pixel accepted without line buffer read");
	a_fix_load: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FIX && !out_valid_q) |=> out_valid_q)
		else $error("result word not loaded into output register");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled result word changed");
`endif

endmodule
